// File: design/mch_pkg.sv
// ----------------------------------------------------------------------------
// mch_pkg: shared types and constants for the magnetometer heading block
// Holds the gain reset values, register indexes, the CORDIC angle table and
// the sequencer state type.
// ----------------------------------------------------------------------------
package mch_pkg;

  localparam int unsigned AxisW    = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned HeadW    = 9;
  localparam int unsigned CordSteps = 16;
  localparam int unsigned StepW    = 4;
  // Vector width: 16-bit value times 65536, plus CORDIC growth and sign.
  localparam int unsigned VecW     = 35;
  localparam int unsigned AngW     = 26;

  localparam logic [GainW-1:0] GainXyRst = 16'd10551;
  localparam logic [GainW-1:0] GainZRst  = 16'd19268;

  localparam logic [0:0] RegGainXy = 1'b0;
  localparam logic [0:0] RegGainZ  = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StNorm,
    StCord,
    StDone
  } mch_state_e;

  function automatic logic signed [AngW-1:0] atan_q16(input logic [StepW-1:0] idx);
    logic signed [AngW-1:0] v;
    case (idx)
      4'd0:  v = 26'sd2949120;
      4'd1:  v = 26'sd1740967;
      4'd2:  v = 26'sd919879;
      4'd3:  v = 26'sd466945;
      4'd4:  v = 26'sd234379;
      4'd5:  v = 26'sd117304;
      4'd6:  v = 26'sd58666;
      4'd7:  v = 26'sd29335;
      4'd8:  v = 26'sd14668;
      4'd9:  v = 26'sd7334;
      4'd10: v = 26'sd3667;
      4'd11: v = 26'sd1833;
      4'd12: v = 26'sd917;
      4'd13: v = 26'sd458;
      4'd14: v = 26'sd229;
      default: v = 26'sd115;
    endcase
    return v;
  endfunction

endpackage

// File: design/magnetometer_calibrate_heading.sv
// Sequence from input transfer to out_valid_o: the three axes in turn through the
// bit-serial multiplier (start, 16 gain bits, done), a normalize step, the CORDIC
// (16 micro-rotations and done) and an output step.
// A new sample is taken only once the last one is through; the input waits until the held
// result has been taken, so a stalled receiver holds off the next sample.
// Reset: asynchronous active low; gains to defaults, min 32767, max -32768.
// ----------------------------------------------------------------------------
// magnetometer_calibrate_heading: hard-iron calibration and compass heading
// Scales each axis, tracks per-axis extremes, removes the midpoint and
// computes the heading from the normalized x and y.
// ----------------------------------------------------------------------------
module magnetometer_calibrate_heading (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [mch_pkg::AxisW-1:0]  raw_x_i,
  input  logic signed [mch_pkg::AxisW-1:0]  raw_y_i,
  input  logic signed [mch_pkg::AxisW-1:0]  raw_z_i,
  input  logic                              seed_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [mch_pkg::AxisW-1:0]  norm_x_o,
  output logic signed [mch_pkg::AxisW-1:0]  norm_y_o,
  output logic signed [mch_pkg::AxisW-1:0]  norm_z_o,
  output logic [mch_pkg::HeadW-1:0]         heading_deg_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [0:0]                        cfg_index_i,
  input  logic [mch_pkg::GainW-1:0]         cfg_data_i
);
  import mch_pkg::*;

  mch_state_e state_q, state_d;
  logic [GainW-1:0] gxy_q, gz_q;
  logic signed [AxisW-1:0] raw_q [3];
  logic signed [AxisW-1:0] s_q [3];
  logic signed [AxisW-1:0] min_q [3];
  logic signed [AxisW-1:0] max_q [3];
  logic signed [AxisW-1:0] n_q [3];
  logic seed_q;
  logic [1:0] ax_q, ax_d;
  logic mul_start, mul_done, cord_start, cord_done;
  logic [AxisW:0] prod;
  logic [AxisW-1:0] mag;
  logic [HeadW-1:0] head;
  logic signed [AxisW-1:0] sres;
  logic ovalid_q;
  logic signed [AxisW-1:0] nmin [3], nmax [3], nval [3];
  logic signed [AxisW:0]   sum [3], mid [3], diff [3];

  // The input side waits until the held result has been taken.
  assign in_ready_o  = (state_q == StIdle) && !ovalid_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gxy_q <= GainXyRst;
      gz_q  <= GainZRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegGainXy: gxy_q <= cfg_data_i;
        RegGainZ:  gz_q  <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // Magnitude of the current axis; -32768 becomes 32768 in 16 unsigned bits.
  assign mag = raw_q[ax_q][AxisW-1] ? AxisW'(-raw_q[ax_q]) : raw_q[ax_q];
  assign sres = raw_q[ax_q][AxisW-1] ? -AxisW'(prod) : AxisW'(prod);

  mch_serial_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .mag_i(mag),
    .gain_i((ax_q == 2'd2) ? gz_q : gxy_q), .prod_o(prod), .done_o(mul_done)
  );

  // The CORDIC takes the normalized x and y in the same cycle they are stored.
  mch_cordic u_cord (
    .clk_i, .rst_ni, .start_i(cord_start), .x_i(nval[0]), .y_i(nval[1]),
    .head_o(head), .done_o(cord_done)
  );

  logic mul_go_q;
  always_comb begin
    state_d = state_q; ax_d = ax_q; mul_start = 1'b0; cord_start = 1'b0;
    case (state_q)
      StIdle: if (in_valid_i && in_ready_o) begin
        state_d = StMul; ax_d = 2'd0;
      end
      StMul: begin
        mul_start = mul_go_q;
        if (mul_done) begin
          if (ax_q == 2'd2) state_d = StNorm;
          else ax_d = ax_q + 2'd1;
        end
      end
      StNorm: begin
        state_d = StCord; cord_start = 1'b1;
      end
      StCord: if (cord_done) state_d = StDone;
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ax_q     <= '0;
      ovalid_q <= 1'b0;
      mul_go_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        min_q[k] <= 16'sh7fff;
        max_q[k] <= 16'sh8000;
      end
    end else begin
      state_q  <= state_d;
      ax_q     <= ax_d;
      mul_go_q <= (state_q == StIdle && in_valid_i && in_ready_o) ||
                  (state_q == StMul && mul_done && ax_q != 2'd2);
      if (state_q == StDone) ovalid_q <= 1'b1;
      else if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      if (state_q == StNorm) begin
        for (int k = 0; k < 3; k++) begin
          if (seed_q) begin
            min_q[k] <= s_q[k];
            max_q[k] <= s_q[k];
          end else begin
            if (s_q[k] < min_q[k]) min_q[k] <= s_q[k];
            if (s_q[k] > max_q[k]) max_q[k] <= s_q[k];
          end
        end
      end
    end
  end

  // Normalize: midpoint of the updated range, truncated toward zero.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nmin[k] = seed_q ? s_q[k] : ((s_q[k] < min_q[k]) ? s_q[k] : min_q[k]);
      nmax[k] = seed_q ? s_q[k] : ((s_q[k] > max_q[k]) ? s_q[k] : max_q[k]);
      sum[k]  = (AxisW+1)'(nmax[k]) + (AxisW+1)'(nmin[k]);
      mid[k]  = (sum[k] + $signed({{AxisW{1'b0}}, sum[k][AxisW]})) >>> 1;
      diff[k] = (AxisW+1)'(s_q[k]) - mid[k];
      if (diff[k] > 17'sd32767) nval[k] = 16'sh7fff;
      else if (diff[k] < -17'sd32768) nval[k] = 16'sh8000;
      else nval[k] = diff[k][AxisW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i && in_ready_o) begin
      raw_q[0] <= raw_x_i; raw_q[1] <= raw_y_i; raw_q[2] <= raw_z_i;
      seed_q <= seed_i;
    end
    if (state_q == StMul && mul_done) s_q[ax_q] <= sres;
    if (state_q == StNorm) begin
      for (int k = 0; k < 3; k++) n_q[k] <= nval[k];
    end
    if (state_q == StDone) heading_deg_o <= head;
  end

  assign norm_x_o    = n_q[0];
  assign norm_y_o    = n_q[1];
  assign norm_z_o    = n_q[2];
  assign out_valid_o = ovalid_q;
endmodule

// File: design/mch_serial_mul.sv
// ----------------------------------------------------------------------------
// mch_serial_mul: bit-serial unsigned magnitude times gain
// Shift-and-add over the gain bits, one bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module mch_serial_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mch_pkg::AxisW-1:0]   mag_i,
  input  logic [mch_pkg::GainW-1:0]   gain_i,
  output logic [mch_pkg::AxisW:0]     prod_o,
  output logic                        done_o
);
  import mch_pkg::*;

  logic [AxisW+GainW-1:0] acc_q, acc_d;
  logic [GainW-1:0]       g_q, g_d;
  logic [AxisW-1:0]       m_q, m_d;
  logic [StepW:0]         cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q;

  always_comb begin
    acc_d = acc_q; g_d = g_q; m_d = m_q; cnt_d = cnt_q; busy_d = busy_q;
    if (start_i) begin
      acc_d = '0; g_d = gain_i; m_d = mag_i; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      // Shift the sum right, then add the magnitude at the current bit weight.
      acc_d = ({1'b0, acc_q[AxisW+GainW-1:1]}) +
              ({(AxisW+GainW){1'b0}} | ({{GainW{1'b0}}, m_q} << (AxisW-1)) &
               {(AxisW+GainW){g_q[0]}}) ;
      g_d = {1'b0, g_q[GainW-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == (StepW+1)'(GainW-1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= busy_q && (cnt_q == (StepW+1)'(GainW-1));
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; g_q <= g_d; m_q <= m_d;
  end

  // acc holds m*g after the last gain bit; the upper half is the product >> 16.
  assign prod_o = {1'b0, acc_q[AxisW+GainW-1:GainW]};
  assign done_o = done_q;
endmodule

// File: design/mch_cordic.sv
// ----------------------------------------------------------------------------
// mch_cordic: vectoring CORDIC for the compass heading
// One micro-rotation per cycle with a shared barrel shift per component.
// ----------------------------------------------------------------------------
module mch_cordic (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [mch_pkg::AxisW-1:0]   x_i,
  input  logic signed [mch_pkg::AxisW-1:0]   y_i,
  output logic [mch_pkg::HeadW-1:0]          head_o,
  output logic                               done_o
);
  import mch_pkg::*;

  logic signed [VecW-1:0] vx_q, vx_d, vy_q, vy_d, dx, dy;
  logic signed [AngW-1:0] ang_q, ang_d, angw;
  logic [StepW-1:0]       i_q, i_d;
  logic                   busy_q, busy_d, last;
  logic [HeadW-1:0]       spec_q, spec_d, h;
  logic                   sp_q, sp_d;
  logic signed [VecW-1:0] sx, sy;

  assign last = busy_q && (i_q == StepW'(CordSteps-1));
  assign dx = vy_q >>> i_q;
  assign dy = vx_q >>> i_q;

  always_comb begin
    vx_d = vx_q; vy_d = vy_q; ang_d = ang_q; i_d = i_q; busy_d = busy_q;
    spec_d = spec_q; sp_d = sp_q;
    sx = VecW'(x_i) <<< 16;
    sy = VecW'(y_i) <<< 16;
    if (start_i) begin
      busy_d = 1'b1; i_d = '0; sp_d = 1'b1; spec_d = '0;
      if (y_i == 0) spec_d = (x_i < 0) ? 9'd180 : 9'd0;
      else if (x_i == 0) spec_d = (y_i > 0) ? 9'd90 : 9'd270;
      else if (x_i == y_i) spec_d = (y_i > 0) ? 9'd45 : 9'd225;
      else if (x_i == -y_i) spec_d = (y_i > 0) ? 9'd135 : 9'd315;
      else sp_d = 1'b0;
      if (x_i < 0) begin
        vx_d = -sx; vy_d = -sy; ang_d = 26'sd11796480;
      end else begin
        vx_d = sx; vy_d = sy; ang_d = '0;
      end
    end else if (busy_q) begin
      if (vy_q >= 0) begin
        vx_d = vx_q + dx; vy_d = vy_q - dy; ang_d = ang_q + atan_q16(i_q);
      end else begin
        vx_d = vx_q - dx; vy_d = vy_q + dy; ang_d = ang_q - atan_q16(i_q);
      end
      i_d = i_q + 1'b1;
      if (last) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q    <= '0;
    end else begin
      busy_q <= busy_d;
      i_q    <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vx_q <= vx_d; vy_q <= vy_d; ang_q <= ang_d; spec_q <= spec_d; sp_q <= sp_d;
  end

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= last;
  end

  always_comb begin
    angw = ang_q;
    if (ang_q < 0) angw = ang_q + 26'sd23592960;
    else if (ang_q >= 26'sd23592960) angw = ang_q - 26'sd23592960;
    h = angw[24:16];
    if (h > 9'd359) h = 9'd359;
  end

  assign head_o = sp_q ? spec_q : h;
  assign done_o = done_q;
endmodule
